>>> rtl/core/pdb_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pdb_pkg: shared types for the Porter-Duff pixel blender
// Mode codes, pixel payload structs, per-pixel coefficient set, stage enables.
// ----------------------------------------------------------------------------
package pdb_pkg;

  typedef enum logic [3:0] {
    MODE_CLEAR   = 4'd0,
    MODE_SRC     = 4'd1,
    MODE_DST     = 4'd2,
    MODE_SRCOVER = 4'd3,
    MODE_DSTOVER = 4'd4,
    MODE_SRCIN   = 4'd5,
    MODE_DSTIN   = 4'd6,
    MODE_SRCOUT  = 4'd7,
    MODE_DSTOUT  = 4'd8,
    MODE_SRCATOP = 4'd9,
    MODE_DSTATOP = 4'd10,
    MODE_XOR     = 4'd11
  } pdb_mode_e;

  // Term that is added undivided to the scaled product sum.
  typedef enum logic [1:0] {
    BASE_ZERO = 2'd0,
    BASE_SRC  = 2'd1,
    BASE_DST  = 2'd2
  } pdb_base_e;

  localparam logic [7:0] ALPHA_FULL = 8'd255;
  localparam logic [7:0] ALPHA_NONE = 8'd0;
  localparam logic [7:0] ROUND_HALF = 8'd128;

  typedef struct packed {
    logic [7:0] src_alpha;
    logic [7:0] src_red;
    logic [7:0] src_green;
    logic [7:0] src_blue;
    logic [7:0] dst_alpha;
    logic [7:0] dst_red;
    logic [7:0] dst_green;
    logic [7:0] dst_blue;
  } pdb_in_t;

  typedef struct packed {
    logic [7:0] out_alpha;
    logic [7:0] out_red;
    logic [7:0] out_green;
    logic [7:0] out_blue;
  } pdb_out_t;

  // Per pixel: r = base + div255(src_k * s + dst_k * d), same for all channels.
  typedef struct packed {
    pdb_base_e  base_sel;
    logic [7:0] src_k;
    logic [7:0] dst_k;
  } pdb_coef_t;

  // Load enables of the four register stages.
  typedef struct packed {
    logic s1;
    logic s2;
    logic s3;
    logic s4;
  } pdb_adv_t;

endpackage

>>> rtl/core/pdb_coef.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pdb_coef: mode decode stage
// Turns mode and the two alphas into one coefficient set; registers pixel too.
// ----------------------------------------------------------------------------
module pdb_coef import pdb_pkg::*; (
  input  logic      clk_i,
  input  logic      en_i,
  input  pdb_mode_e mode_i,
  input  pdb_in_t   pix_i,
  output pdb_in_t   pix_o,
  output pdb_coef_t coef_o
);

  pdb_coef_t coef_d, coef_q;
  pdb_in_t   pix_q;
  logic      sa_full, sa_none, da_full, da_none;
  logic [7:0] inv_sa, inv_da;

  assign sa_full = (pix_i.src_alpha == ALPHA_FULL);
  assign sa_none = (pix_i.src_alpha == ALPHA_NONE);
  assign da_full = (pix_i.dst_alpha == ALPHA_FULL);
  assign da_none = (pix_i.dst_alpha == ALPHA_NONE);
  assign inv_sa  = ALPHA_FULL - pix_i.src_alpha;
  assign inv_da  = ALPHA_FULL - pix_i.dst_alpha;

  always_comb begin
    coef_d.base_sel = BASE_ZERO;
    coef_d.src_k    = 8'd0;
    coef_d.dst_k    = 8'd0;
    unique case (mode_i)
      MODE_SRC: coef_d.base_sel = BASE_SRC;
      MODE_DST: coef_d.base_sel = BASE_DST;
      MODE_SRCOVER: begin
        coef_d.base_sel = BASE_SRC;
        if (!(sa_full || da_none)) coef_d.dst_k = inv_sa;
      end
      MODE_DSTOVER: begin
        priority if (da_none) begin
          coef_d.base_sel = BASE_SRC;
        end else if (da_full || sa_none) begin
          coef_d.base_sel = BASE_DST;
        end else begin
          coef_d.base_sel = BASE_DST;
          coef_d.src_k    = inv_da;
        end
      end
      MODE_SRCIN: begin
        priority if (da_none || sa_none) begin
          coef_d.base_sel = BASE_ZERO;
        end else if (da_full) begin
          coef_d.base_sel = BASE_SRC;
        end else begin
          coef_d.src_k = pix_i.dst_alpha;
        end
      end
      MODE_DSTIN: begin
        if (!(sa_none || da_none)) coef_d.dst_k = pix_i.src_alpha;
      end
      MODE_SRCOUT: begin
        priority if (da_full || sa_none) begin
          coef_d.base_sel = BASE_ZERO;
        end else if (da_none) begin
          coef_d.base_sel = BASE_SRC;
        end else begin
          coef_d.src_k = inv_da;
        end
      end
      MODE_DSTOUT: begin
        if (!(sa_full || da_none)) coef_d.dst_k = inv_sa;
      end
      MODE_SRCATOP: begin
        if (!da_none) begin
          coef_d.src_k = pix_i.dst_alpha;
          coef_d.dst_k = inv_sa;
        end
      end
      MODE_DSTATOP: begin
        if (!sa_none) begin
          coef_d.src_k = inv_da;
          coef_d.dst_k = pix_i.src_alpha;
        end
      end
      MODE_XOR: begin
        priority if (sa_full || da_none) begin
          coef_d.src_k = inv_da;
        end else if (da_full || sa_none) begin
          coef_d.dst_k = inv_sa;
        end else begin
          coef_d.src_k = inv_da;
          coef_d.dst_k = inv_sa;
        end
      end
      default: coef_d.base_sel = BASE_ZERO;  // clear and unused codes
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      coef_q <= coef_d;
      pix_q  <= pix_i;
    end
  end

  assign coef_o = coef_q;
  assign pix_o  = pix_q;

endmodule

>>> rtl/core/pdb_chan.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pdb_chan: one channel datapath, three register stages
// Multiply, sum with rounding bias, scale by 257/65536 then add base and clamp.
// ----------------------------------------------------------------------------
module pdb_chan import pdb_pkg::*; (
  input  logic       clk_i,
  input  pdb_adv_t   adv_i,
  input  pdb_coef_t  coef_i,
  input  logic [7:0] s_i,
  input  logic [7:0] d_i,
  output logic [7:0] r_o
);

  logic [15:0] src_prod_q, dst_prod_q;
  logic [7:0]  base_d, base2_q, base3_q;
  logic [17:0] sum_d, sum_q;
  logic [25:0] scaled;
  logic [9:0]  quot;
  logic [10:0] total;
  logic [7:0]  r_d, r_q;

  always_comb begin
    unique case (coef_i.base_sel)
      BASE_SRC: base_d = s_i;
      BASE_DST: base_d = d_i;
      default:  base_d = 8'd0;
    endcase
  end

  // stage 2: products
  always_ff @(posedge clk_i) begin
    if (adv_i.s2) begin
      src_prod_q <= {8'd0, coef_i.src_k} * {8'd0, s_i};
      dst_prod_q <= {8'd0, coef_i.dst_k} * {8'd0, d_i};
      base2_q    <= base_d;
    end
  end

  // stage 3: sum plus rounding bias, max 130178
  assign sum_d = {2'b00, src_prod_q} + {2'b00, dst_prod_q} + {10'd0, ROUND_HALF};

  always_ff @(posedge clk_i) begin
    if (adv_i.s3) begin
      sum_q   <= sum_d;
      base3_q <= base2_q;
    end
  end

  // stage 4: x*257 = (x << 8) + x, keep bits 25:16
  assign scaled = {sum_q, 8'd0} + {8'd0, sum_q};
  assign quot   = scaled[25:16];
  assign total  = {3'd0, base3_q} + {1'b0, quot};
  assign r_d    = (total > 11'd255) ? 8'd255 : total[7:0];

  always_ff @(posedge clk_i) begin
    if (adv_i.s4) r_q <= r_d;
  end

  assign r_o = r_q;

endmodule

>>> rtl/core/porter_duff_pixel_blend.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// porter_duff_pixel_blend: premultiplied ARGB8888 Porter-Duff compositor
// Twelve modes on a src/dst pixel pair, one pixel per clock unless stalled.
// ----------------------------------------------------------------------------
// Blends one premultiplied source and destination pixel under the mode held
// in the blend mode register (reset: src-over; codes 12 to 15 give zero).
// A new pixel is taken every cycle while the input is not stalled, and
// each pixel passes the four register stages in order: mode decode, 8x8
// multiply, product sum, and scale/saturate, which is the output register.
// Each stage holds one pixel with its own valid bit and loads whenever its
// slot is free or moving on, so a stalled output only backs up the stages
// that are full. Write the mode register only while the pipeline is empty.
// ----------------------------------------------------------------------------
module porter_duff_pixel_blend import pdb_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  // mode register write
  input  logic       cfg_we_i,
  input  logic [3:0] cfg_wdata_i,
  // pixel pair in
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  pdb_in_t    in_data_i,
  // blended pixel out
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output pdb_out_t   out_data_o
);

  pdb_mode_e mode_q;
  logic      v1_q, v2_q, v3_q, v4_q;
  pdb_adv_t  adv;
  pdb_in_t   pix1;
  pdb_coef_t coef1;

  // Blend mode register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= MODE_SRCOVER;
    end else if (cfg_we_i) begin
      mode_q <= pdb_mode_e'(cfg_wdata_i);
    end
  end

  // A stage loads when it is empty or its content moves on this cycle.
  assign adv.s4     = !v4_q || !out_stall_i;
  assign adv.s3     = !v3_q || adv.s4;
  assign adv.s2     = !v2_q || adv.s3;
  assign adv.s1     = !v1_q || adv.s2;
  assign in_stall_o = !adv.s1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else begin
      if (adv.s1) v1_q <= in_valid_i;
      if (adv.s2) v2_q <= v1_q;
      if (adv.s3) v3_q <= v2_q;
      if (adv.s4) v4_q <= v3_q;
    end
  end

  // Stage 1: mode decode into one coefficient set for all four channels
  pdb_coef u_coef (
    .clk_i  (clk_i),
    .en_i   (adv.s1),
    .mode_i (mode_q),
    .pix_i  (in_data_i),
    .pix_o  (pix1),
    .coef_o (coef1)
  );

  // Stages 2-4: one datapath per channel
  pdb_chan u_chan_a (
    .clk_i  (clk_i),
    .adv_i  (adv),
    .coef_i (coef1),
    .s_i    (pix1.src_alpha),
    .d_i    (pix1.dst_alpha),
    .r_o    (out_data_o.out_alpha)
  );

  pdb_chan u_chan_r (
    .clk_i  (clk_i),
    .adv_i  (adv),
    .coef_i (coef1),
    .s_i    (pix1.src_red),
    .d_i    (pix1.dst_red),
    .r_o    (out_data_o.out_red)
  );

  pdb_chan u_chan_g (
    .clk_i  (clk_i),
    .adv_i  (adv),
    .coef_i (coef1),
    .s_i    (pix1.src_green),
    .d_i    (pix1.dst_green),
    .r_o    (out_data_o.out_green)
  );

  pdb_chan u_chan_b (
    .clk_i  (clk_i),
    .adv_i  (adv),
    .coef_i (coef1),
    .s_i    (pix1.src_blue),
    .d_i    (pix1.dst_blue),
    .r_o    (out_data_o.out_blue)
  );

  assign out_valid_o = v4_q;

  // Input backs up only when every stage is full and the output is stalled.
  a_stall_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (v1_q && v2_q && v3_q && v4_q && out_stall_i))
    else $error("input stalled with a free pipeline slot");

  // A free-running output never throttles the input.
  a_no_bubble: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_stall_i |-> !in_stall_o)
    else $error("input stalled while output drains");

  // An accepted pixel always lands in stage 1.
  a_accept_lands: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> v1_q)
    else $error("accepted pixel lost at stage 1");

endmodule
